FILE: hw/rtl/odometer_packet_accumulator_assert.svh
// Assertion macros for the checker file of the odometer accumulator.
// Each macro expects signals clk and arst_n in scope.
`ifndef ODOMETER_PACKET_ACCUMULATOR_ASSERT_SVH
`define ODOMETER_PACKET_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define ODO_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define ODO_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/odo_pkg.sv
// ----------------------------------------------------------------------------
// odo_pkg
// Types and fixed constants of the odometer packet accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package odo_pkg;

	// Operation codes carried in the op field
	localparam logic [1:0] OP_BYTE  = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;

	// Frame markers
	localparam logic [7:0] START_BYTE = 8'h08;
	localparam logic [7:0] HEAD_BYTE  = 8'h02;
	localparam logic [7:0] TAIL_BYTE  = 8'h03;

	// Byte position of the trailer within a frame
	localparam logic [2:0] LAST_COUNT = 3'd7;

	// 0.17541436 mm per count in Q0.16
	localparam logic [15:0] SCALE_RESET = 16'd11496;
	localparam logic [7:0]  DUTY_MAX    = 8'd100;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  rx_byte;
		logic [7:0]  duty;
		logic [3:0]  entry_index;
		logic [15:0] entry_value;
	} in_item_t;

	typedef struct packed {
		logic               frame_good;
		logic signed [15:0] delta_x;
		logic signed [15:0] delta_y;
		logic signed [31:0] total_count_x;
		logic signed [31:0] total_count_y;
		logic signed [47:0] total_mm_x;
		logic signed [47:0] total_mm_y;
	} out_item_t;

	// Status of the frame assembler towards the accumulator
	typedef struct packed {
		logic               last;
		logic               good;
		logic signed [15:0] dx;
		logic signed [15:0] dy;
	} frame_t;

	// Scale table index: (min(duty,100)+5)/10, division by ten done as
	// a multiply by 205 and a shift right by 11 (exact below 1029).
	function automatic logic [3:0] duty_to_index(input logic [7:0] duty);
		logic [6:0]  d;
		logic [6:0]  t;
		logic [14:0] p;
		d = (duty > DUTY_MAX) ? DUTY_MAX[6:0] : duty[6:0];
		t = d + 7'd5;
		p = 15'(t) * 15'd205;
		return p[14:11];
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/odo_frame.sv
// ----------------------------------------------------------------------------
// odo_frame
// Hunts for the start byte and assembles the eight-byte odometer frame.
// ----------------------------------------------------------------------------
`default_nettype none

module odo_frame import odo_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] rx_byte,
	output frame_t          frame
);

	logic       in_frame_q;
	logic [2:0] count_q;
	logic [7:0] head_q;
	logic [7:0] dx_lo_q;
	logic [7:0] dx_hi_q;
	logic [7:0] dy_lo_q;
	logic [7:0] dy_hi_q;

	// Advance the position counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			count_q    <= '0;
		end else if (step) begin
			if (!in_frame_q) begin
				if (rx_byte == START_BYTE) begin
					in_frame_q <= 1'b1;
					count_q    <= 3'd1;
				end
			end else if (count_q != LAST_COUNT) begin
				count_q <= count_q + 3'd1;
			end else begin
				in_frame_q <= 1'b0;
				count_q    <= '0;
			end
		end
	end

	// Hold the bytes that carry the header and the deltas
	always_ff @(posedge clk) begin
		if (step && in_frame_q) begin
			unique case (count_q)
				3'd1: head_q  <= rx_byte;
				3'd2: dx_lo_q <= rx_byte;
				3'd3: dx_hi_q <= rx_byte;
				3'd4: dy_lo_q <= rx_byte;
				3'd5: dy_hi_q <= rx_byte;
				default: ;
			endcase
		end
	end

	assign frame.last = in_frame_q && (count_q == LAST_COUNT);
	assign frame.good = (head_q == HEAD_BYTE) && (rx_byte == TAIL_BYTE);
	assign frame.dx   = {dx_hi_q, dx_lo_q};
	assign frame.dy   = {dy_hi_q, dy_lo_q};

endmodule

`default_nettype wire

FILE: hw/rtl/odometer_packet_accumulator.sv
// ----------------------------------------------------------------------------
// odometer_packet_accumulator
// Odometer UART frame decoder with count and millimetre distance totals.
// ----------------------------------------------------------------------------
// Takes one item per clock: a received UART byte, a clear of the totals or a
// write of one scale table entry. Bytes are searched for the start byte 0x08
// and grouped into eight-byte frames; the eighth byte of each frame produces
// one result item, flagged good when byte 1 is 0x02 and byte 7 is 0x03. A
// good frame adds its signed x and y deltas to 32-bit count totals and
// delta times the Q0.16 scale, picked by the duty of the item that carries
// the eighth byte, to 48-bit Q32.16 millimetre totals, all wrapping. A bad
// frame reports its deltas but leaves the totals alone. An item is latched
// into the input register at acceptance and processed from there; a result
// is then written into the result register and held there until it is taken.
// The block sustains one item per cycle; it stalls only while the result
// register is full and out_ready is low, and then only if the waiting item
// would make a result. The critical path is the duty-indexed scale lookup
// feeding one 16x17 signed multiply and a 48-bit add.
// ----------------------------------------------------------------------------
`default_nettype none

module odometer_packet_accumulator import odo_pkg::*; #(
	parameter int SCALE_ENTRIES = 11
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_item_t in_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output out_item_t     out_data
);

	localparam int IDX_W = (SCALE_ENTRIES > 1) ? $clog2(SCALE_ENTRIES) : 1;

	// Input register
	logic     valid_s1;
	in_item_t item_s1;

	// Totals and scale table
	logic signed [31:0] cnt_x_q;
	logic signed [31:0] cnt_y_q;
	logic signed [47:0] mm_x_q;
	logic signed [47:0] mm_y_q;
	logic [15:0]        scale_q [SCALE_ENTRIES];

	// Result register
	logic      out_valid_q;
	out_item_t out_q;

	frame_t frm;
	logic   res_s1;
	logic   advance;
	logic   add_s1;
	logic   clr_s1;
	logic   wr_s1;

	logic [5:0]         wr_idx;
	logic [5:0]         rd_full;
	logic [5:0]         rd_idx;
	logic [15:0]        scale;
	logic signed [32:0] prod_x;
	logic signed [32:0] prod_y;
	logic signed [31:0] cnt_x_nxt;
	logic signed [31:0] cnt_y_nxt;
	logic signed [47:0] mm_x_nxt;
	logic signed [47:0] mm_y_nxt;

	// Result is due when a byte item lands on the trailer position
	assign res_s1  = valid_s1 && (item_s1.op == OP_BYTE) && frm.last;
	// Advance unless a result would overwrite one still waiting
	assign advance = valid_s1 && (!res_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign add_s1 = advance && res_s1 && frm.good;
	assign clr_s1 = advance && (item_s1.op == OP_CLEAR);
	assign wr_s1  = advance && (item_s1.op == OP_WRITE)
		&& (wr_idx < 6'(SCALE_ENTRIES));

	odo_frame u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance && (item_s1.op == OP_BYTE)),
		.rx_byte (item_s1.rx_byte),
		.frame   (frm)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	// Scale lookup: saturate the duty index to the last entry
	assign wr_idx  = 6'(item_s1.entry_index);
	assign rd_full = 6'(duty_to_index(item_s1.duty));
	assign rd_idx  = (rd_full >= 6'(SCALE_ENTRIES)) ? 6'(SCALE_ENTRIES - 1) : rd_full;
	assign scale   = scale_q[rd_idx[IDX_W-1:0]];

	// Exact Q17.16 products, sign-extended into the 48-bit totals
	assign prod_x = frm.dx * $signed({1'b0, scale});
	assign prod_y = frm.dy * $signed({1'b0, scale});

	assign cnt_x_nxt = add_s1 ? cnt_x_q + 32'(frm.dx) : cnt_x_q;
	assign cnt_y_nxt = add_s1 ? cnt_y_q + 32'(frm.dy) : cnt_y_q;
	assign mm_x_nxt  = add_s1 ? mm_x_q + 48'(prod_x) : mm_x_q;
	assign mm_y_nxt  = add_s1 ? mm_y_q + 48'(prod_y) : mm_y_q;

	// Accumulate, or zero on a clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_x_q <= '0;
			cnt_y_q <= '0;
			mm_x_q  <= '0;
			mm_y_q  <= '0;
		end else if (clr_s1) begin
			cnt_x_q <= '0;
			cnt_y_q <= '0;
			mm_x_q  <= '0;
			mm_y_q  <= '0;
		end else begin
			cnt_x_q <= cnt_x_nxt;
			cnt_y_q <= cnt_y_nxt;
			mm_x_q  <= mm_x_nxt;
			mm_y_q  <= mm_y_nxt;
		end
	end

	// Load one scale entry; out-of-range writes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SCALE_ENTRIES; i++) begin
				scale_q[i] <= SCALE_RESET;
			end
		end else if (wr_s1) begin
			for (int i = 0; i < SCALE_ENTRIES; i++) begin
				if (wr_idx == 6'(i)) begin
					scale_q[i] <= item_s1.entry_value;
				end
			end
		end
	end

	// Result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_s1) begin
			out_q.frame_good    <= frm.good;
			out_q.delta_x       <= frm.dx;
			out_q.delta_y       <= frm.dy;
			out_q.total_count_x <= cnt_x_nxt;
			out_q.total_count_y <= cnt_y_nxt;
			out_q.total_mm_x    <= mm_x_nxt;
			out_q.total_mm_y    <= mm_y_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

FILE: hw/rtl/odo_assert.sv
// ----------------------------------------------------------------------------
// odo_assert
// Port-level checks of the odometer packet accumulator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "odometer_packet_accumulator_assert.svh"

module odo_assert import odo_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_ready,
	input wire in_item_t  in_data,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire out_item_t out_data
);

	// Result channel keeps its item while stalled
	`ODO_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result item changed or dropped while stalled")

	// Input side never stalls when the result slot is free or being drained
	`ODO_ASSERT_NOW(a_in_free, !out_valid || out_ready, in_ready, "input stalled with free result slot")

	// No result in the first cycle after reset
	`ODO_ASSERT_NOW(a_rst_quiet, $past(!arst_n), !out_valid, "result shown straight after reset")

	// A result cannot appear unless it follows an accepted input item or a stalled input side
	`ODO_ASSERT_NOW(a_no_invent, $rose(out_valid), $past(in_valid && in_ready) || $past(in_valid && in_ready, 2) || $past(!in_ready), "result appeared without input")

endmodule

bind odometer_packet_accumulator odo_assert u_odo_assert (.*);

`default_nettype wire
